### rtl/modular_exponentiation_inverse_assert.svh
// Assertion macros for the checker file.
`ifndef MODULAR_EXPONENTIATION_INVERSE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_INVERSE_ASSERT_SVH

// Same-cycle implication.
`define MEXPI_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEXPI_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mexpi_pkg.sv
package mexpi_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CntW  = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_WAIT,
    ST_SQ_ISSUE,
    ST_SQ_WAIT,
    ST_MUL_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] prod;
  } mm_rsp_t;

endpackage

### rtl/mexpi_modmul.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
module mexpi_modmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexpi_pkg::mm_req_t req_i,
  output mexpi_pkg::mm_rsp_t rsp_o
);
  import mexpi_pkg::*;

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [WIDTH:0] dbl, red1, sum, msum;

  always_comb begin
    msum = {1'b0, req_i.m};
    dbl  = {acc_q, 1'b0};
    red1 = (dbl >= msum) ? (dbl - msum) : dbl;
    sum  = red1 + (b_q[WIDTH-1] ? {1'b0, a_q} : '0);
    sum  = (sum >= msum) ? (sum - msum) : sum;
    acc_d = sum[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      acc_q <= '0;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      cnt_q <= CntW'(WIDTH - 1);
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[WIDTH-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

### rtl/modular_exponentiation_inverse.sv
// Modular exponentiation: result = base^exponent mod modulus (opcode 0), or the
// Fermat inverse base^(modulus-2) mod modulus (opcode 1, prime modulus only).
// Command channel: a word is taken at a clock edge with start high and busy low;
// busy stays high until the result has been shown. The result appears on
// result_o for exactly one cycle with done_o high; the receiver cannot stall.
// Config channel: cfg_data_i is written into the modulus at an edge with
// cfg_valid_i and cfg_ready_o high; ready is high only while idle with start low.
// One bit-serial modular multiplier is shared for everything: the base
// reduction (1 * base), every square and every multiply. A square is started
// from its own issue state; a multiply starts as soon as its square is done.
// Each exponent bit, MSB first, takes a square and, if set, a multiply. After
// the result the block returns to idle before the next word is taken. Modulus
// below two shows result zero in the cycle after the accept; for the inverse, a
// base that reduces to zero shows zero once the base reduction is done. One item
// at a time. Reset returns to idle and sets the modulus to two.
module modular_exponentiation_inverse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode_i,
  input  logic [mexpi_pkg::WIDTH-1:0] base_i,
  input  logic [mexpi_pkg::WIDTH-1:0] exponent_i,
  output logic                        done_o,
  output logic [mexpi_pkg::WIDTH-1:0] result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mexpi_pkg::WIDTH-1:0] cfg_data_i
);
  import mexpi_pkg::*;

  state_e state_q, state_d;

  logic [WIDTH-1:0] mod_q;
  logic             op_q;
  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] base_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] res_q;
  logic [CntW-1:0]  cnt_q;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  mexpi_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q   <= WIDTH'(2);
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mod_q <= cfg_data_i;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (mod_q < WIDTH'(2)) ? ST_DONE : ST_RED_WAIT;
        end
      end
      ST_RED_WAIT: begin
        if (mm_rsp.done) begin
          state_d = (op_q && (mm_rsp.prod == '0)) ? ST_DONE : ST_SQ_ISSUE;
        end
      end
      ST_SQ_ISSUE: state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          if (exp_q[WIDTH-1]) begin
            state_d = ST_MUL_WAIT;
          end else begin
            state_d = (cnt_q == '0) ? ST_DONE : ST_SQ_ISSUE;
          end
        end
      end
      ST_MUL_WAIT: begin
        if (mm_rsp.done) begin
          state_d = (cnt_q == '0) ? ST_DONE : ST_SQ_ISSUE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier requests
  always_comb begin
    busy         = 1'b1;
    done_o       = 1'b0;
    cfg_ready_o  = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = acc_q;
    mm_req.b     = acc_q;
    mm_req.m     = mod_q;
    unique case (state_q)
      ST_IDLE: begin
        busy         = 1'b0;
        cfg_ready_o  = !start;
        mm_req.start = start && (mod_q >= WIDTH'(2));
        mm_req.a     = WIDTH'(1);
        mm_req.b     = base_i;
      end
      ST_RED_WAIT: ;
      ST_SQ_ISSUE: mm_req.start = 1'b1;
      ST_SQ_WAIT: begin
        mm_req.start = mm_rsp.done && exp_q[WIDTH-1];
        mm_req.a     = mm_rsp.prod;
        mm_req.b     = base_q;
      end
      ST_MUL_WAIT: ;
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_q  <= opcode_i;
          exp_q <= opcode_i ? (mod_q - WIDTH'(2)) : exponent_i;
          res_q <= '0;
        end
      end
      ST_RED_WAIT: begin
        if (mm_rsp.done) begin
          base_q <= mm_rsp.prod;
          acc_q  <= WIDTH'(1);
          cnt_q  <= CntW'(WIDTH - 1);
          res_q  <= '0;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          acc_q <= mm_rsp.prod;
          res_q <= mm_rsp.prod;
          exp_q <= {exp_q[WIDTH-2:0], 1'b0};
          if (!exp_q[WIDTH-1] && (cnt_q != '0)) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
      ST_MUL_WAIT: begin
        if (mm_rsp.done) begin
          acc_q <= mm_rsp.prod;
          res_q <= mm_rsp.prod;
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o = res_q;

endmodule

### rtl/mexpi_checker.sv
`include "modular_exponentiation_inverse_assert.svh"

module mexpi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_ready_o
);

  `MEXPI_ASSERT_NOW(a_done_busy, done_o, busy, "result strobe while not busy")
  `MEXPI_ASSERT_NEXT(a_done_idle, done_o, !busy && !done_o, "no return to idle after result")
  `MEXPI_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not go busy")
  `MEXPI_ASSERT_NEXT(a_busy_hold, busy && !done_o, busy, "busy dropped without a result")
  `MEXPI_ASSERT_NOW(a_cfg_idle, cfg_ready_o, !busy, "config ready while busy")

endmodule

bind modular_exponentiation_inverse mexpi_checker u_mexpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .cfg_ready_o (cfg_ready_o)
);
